// ----- rtl/core/csvfs_pkg.sv -----
`timescale 1ns / 1ps

package csvfs_pkg;

   localparam int HOLD_DEPTH = 32;
   localparam int ADDR_W     = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int COUNT_W    = $clog2(HOLD_DEPTH + 1);

   localparam logic [7:0] QUOTE_CH = 8'h22;
   localparam logic [7:0] COMMA_CH = 8'h2C;
   localparam logic [7:0] SPACE_CH = 8'h20;
   localparam logic [7:0] TAB_CH   = 8'h09;
   localparam logic [7:0] CR_CH    = 8'h0D;

   typedef struct packed {
      logic [7:0] data;
      logic       field_end;
      logic       line_end;
      logic       ws_overflow;
   } item_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == SPACE_CH) || ((b >= TAB_CH) && (b <= CR_CH));
   endfunction

endpackage

// ----- rtl/core/csvfs_hold_ram.sv -----
`timescale 1ns / 1ps

module csvfs_hold_ram (
   input  logic                     clock,
   input  csvfs_pkg::ram_req_type   ram_req,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [csvfs_pkg::HOLD_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_ff <= mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/csv_field_splitter.sv -----
`timescale 1ns / 1ps
// A beat is decoded into the work queue registers; its results then pass to the output register.
// Results leave one at a time: first the held whitespace bytes a byte releases, then its data byte
// and field-end marks; a new byte is taken when idle or as the last result goes out.
// Held bytes come one a cycle, unless the output stalls, through the hold RAM's single read port.
// Reset clears parse mode, held count, overflow mark and pending work; the hold RAM is not cleared.

module csv_field_splitter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // line_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [0] field_end, [1] line_end, [2] ws_overflow
   output logic       rsp_tlast    // last
);

   typedef enum logic [2:0] {
      MODE_LEAD   = 3'd0,
      MODE_UNQ    = 3'd1,
      MODE_QUOTED = 3'd2,
      MODE_QSEEN  = 3'd3
   } mode_type;

   localparam int ITEMS = 3;

   mode_type                          mode_ff, mode_in;
   logic [csvfs_pkg::COUNT_W-1:0]     cnt_ff, cnt_in;
   logic                              ov_ff, ov_in;
   logic [csvfs_pkg::COUNT_W-1:0]     flush_ff, flush_in, flush_dec;
   logic [csvfs_pkg::ADDR_W-1:0]      ptr_ff, ptr_in;
   csvfs_pkg::item_type               items_ff [ITEMS];
   csvfs_pkg::item_type               items_in [ITEMS];
   csvfs_pkg::item_type               dec_items [ITEMS];
   logic [1:0]                        nitems_ff, nitems_in, dec_n;

   logic                              rsp_valid_ff;
   csvfs_pkg::item_type               rsp_item_ff;
   logic                              rsp_last_ff;

   csvfs_pkg::ram_req_type            ram_req;
   logic [7:0]                        rd_data;

   logic                              out_free, emit_flush, emit_item, emit_final, accept;
   logic [7:0]                        b;

   csvfs_hold_ram u_hold_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign b          = req_tdata;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_flush = out_free && (flush_ff != '0);
   assign emit_item  = out_free && (flush_ff == '0) && (nitems_ff != 2'd0);
   assign emit_final = emit_item && (nitems_ff == 2'd1);
   assign req_tready = ((flush_ff == '0) && (nitems_ff == 2'd0)) || emit_final;
   assign accept     = req_tvalid && req_tready;

   // parse decode of one beat
   always_comb begin
      logic [1:0] k;
      k         = 2'd0;
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      ov_in     = ov_ff;
      flush_dec = '0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = cnt_ff[csvfs_pkg::ADDR_W-1:0];
      ram_req.wr_data = b;
      ram_req.rd_addr = ptr_in;
      for (int i = 0; i < ITEMS; i++) begin
         dec_items[i] = '0;
      end

      unique case (mode_ff)
         MODE_UNQ, MODE_QUOTED: begin
            if (mode_ff == MODE_QUOTED && b == csvfs_pkg::QUOTE_CH) begin
               mode_in = MODE_QSEEN;
            end else if (mode_ff == MODE_UNQ && b == csvfs_pkg::COMMA_CH) begin
               dec_items[k] = '{data: 8'h00, field_end: 1'b1, line_end: 1'b0,
                                ws_overflow: ov_in};
               k       = k + 2'd1;
               cnt_in  = '0;
               ov_in   = 1'b0;
               mode_in = MODE_LEAD;
            end else if (csvfs_pkg::is_ws(b)) begin
               if (cnt_ff < csvfs_pkg::COUNT_W'(csvfs_pkg::HOLD_DEPTH)) begin
                  ram_req.wr_en = accept;
                  cnt_in        = cnt_ff + 1'b1;
               end else begin
                  ov_in = 1'b1;
               end
            end else begin
               flush_dec    = cnt_ff;
               cnt_in       = '0;
               dec_items[k] = '{data: b, field_end: 1'b0, line_end: 1'b0, ws_overflow: 1'b0};
               k            = k + 2'd1;
            end
         end
         MODE_QSEEN: begin
            if (b == csvfs_pkg::QUOTE_CH) begin
               flush_dec    = cnt_ff;
               cnt_in       = '0;
               dec_items[k] = '{data: b, field_end: 1'b0, line_end: 1'b0, ws_overflow: 1'b0};
               k            = k + 2'd1;
               mode_in      = MODE_QUOTED;
            end else begin
               dec_items[k] = '{data: 8'h00, field_end: 1'b1, line_end: 1'b0,
                                ws_overflow: ov_in};
               k       = k + 2'd1;
               cnt_in  = '0;
               ov_in   = 1'b0;
               mode_in = MODE_LEAD;
               if (b != csvfs_pkg::COMMA_CH && !csvfs_pkg::is_ws(b)) begin
                  if (b == csvfs_pkg::QUOTE_CH) begin
                     mode_in = MODE_QUOTED;
                  end else begin
                     dec_items[k] = '{data: b, field_end: 1'b0, line_end: 1'b0,
                                      ws_overflow: 1'b0};
                     k       = k + 2'd1;
                     mode_in = MODE_UNQ;
                  end
               end
            end
         end
         default: begin
            mode_in = MODE_LEAD;
            if (!csvfs_pkg::is_ws(b)) begin
               if (b == csvfs_pkg::QUOTE_CH) begin
                  mode_in = MODE_QUOTED;
               end else if (b == csvfs_pkg::COMMA_CH) begin
                  dec_items[k] = '{data: 8'h00, field_end: 1'b1, line_end: 1'b0,
                                   ws_overflow: ov_in};
                  k      = k + 2'd1;
                  cnt_in = '0;
                  ov_in  = 1'b0;
               end else begin
                  dec_items[k] = '{data: b, field_end: 1'b0, line_end: 1'b0,
                                   ws_overflow: 1'b0};
                  k       = k + 2'd1;
                  mode_in = MODE_UNQ;
               end
            end
         end
      endcase

      if (req_tlast) begin
         dec_items[k] = '{data: 8'h00, field_end: 1'b1, line_end: 1'b1, ws_overflow: ov_in};
         k       = k + 2'd1;
         cnt_in  = '0;
         ov_in   = 1'b0;
         mode_in = MODE_LEAD;
      end
      dec_n = k;
   end

   // work queue
   always_comb begin
      flush_in  = flush_ff;
      ptr_in    = ptr_ff;
      nitems_in = nitems_ff;
      for (int i = 0; i < ITEMS; i++) begin
         items_in[i] = items_ff[i];
      end
      if (emit_flush) begin
         flush_in = flush_ff - 1'b1;
         ptr_in   = ptr_ff + 1'b1;
      end
      if (emit_item) begin
         nitems_in = nitems_ff - 2'd1;
         for (int i = 0; i < ITEMS - 1; i++) begin
            items_in[i] = items_ff[i+1];
         end
      end
      if (accept) begin
         flush_in  = flush_dec;
         ptr_in    = '0;
         nitems_in = dec_n;
         for (int i = 0; i < ITEMS; i++) begin
            items_in[i] = dec_items[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_LEAD;
         cnt_ff       <= '0;
         ov_ff        <= 1'b0;
         flush_ff     <= '0;
         ptr_ff       <= '0;
         nitems_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            cnt_ff  <= cnt_in;
            ov_ff   <= ov_in;
         end
         flush_ff  <= flush_in;
         ptr_ff    <= ptr_in;
         nitems_ff <= nitems_in;
         if (emit_flush || emit_item) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ITEMS; i++) begin
         items_ff[i] <= items_in[i];
      end
      if (emit_flush) begin
         rsp_item_ff <= '{data: rd_data, field_end: 1'b0, line_end: 1'b0, ws_overflow: 1'b0};
         rsp_last_ff <= 1'b0;
      end else if (emit_item) begin
         rsp_item_ff <= items_ff[0];
         rsp_last_ff <= emit_final;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff.data;
   assign rsp_tuser  = {rsp_item_ff.ws_overflow, rsp_item_ff.line_end, rsp_item_ff.field_end};
   assign rsp_tlast  = rsp_last_ff;

endmodule
